// ===== rtl/utf8d_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 stream decoder.
// No dependencies; imported by utf8_stream_decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int unsigned CP_W      = 31;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned RQ_DEPTH  = 4;
    localparam int unsigned RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    localparam logic [CP_W-1:0]  REPLACEMENT_CP = CP_W'(32'h0000_fffd);
    localparam logic [LEN_W-1:0] SEEN_MAX       = 3'd7;
    localparam logic [1:0]       CONT_TAG       = 2'b10;

    // One queued result: decoded value plus its end-of-run flag
    typedef struct packed {
        logic            last;
        logic [CP_W-1:0] cp;
    } result_t;

    // Legacy lead-byte length table (0 means not a valid lead byte)
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        begin
            if (b < 8'h80)      len = 3'd1;
            else if (b < 8'hc0) len = 3'd0;
            else if (b < 8'he0) len = 3'd2;
            else if (b < 8'hf0) len = 3'd3;
            else if (b < 8'hf8) len = 3'd4;
            else if (b < 8'hfc) len = 3'd5;
            else if (b < 8'hfe) len = 3'd6;
            else                len = 3'd0;
            return len;
        end
    endfunction

    // Payload bits of a lead byte for a given sequence length
    function automatic logic [7:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [7:0] m;
        begin
            case (len)
                3'd1:    m = 8'h7f;
                3'd2:    m = 8'h1f;
                3'd3:    m = 8'h0f;
                3'd4:    m = 8'h07;
                3'd5:    m = 8'h03;
                3'd6:    m = 8'h01;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: byte stream in, code point stream out.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_axis_*: one text byte per word in tdata[7:0]; tlast marks
//   the final byte of a text. Output channel m_axis_*: one code point per word
//   in tdata[30:0] (0xFFFD for a malformed sequence); tlast marks the last
//   result caused by an input byte.
//   A code point leaves only when the sequence closes: on the next
//   non-continuation byte or on a tlast byte. A byte may cause 0, 1 or 2
//   results. Decoding is done in the accept cycle into the sequence registers
//   and a 4-entry result queue; a result is registered in the queue when the
//   byte that closes it is taken, and m_axis shows the queue head.
//   Throughput: one byte per cycle while the receiver keeps up; s_axis_tready
//   stays high while the queue has two free entries, so a byte giving two
//   results queues both, and the single output port sends them in turn.
//   Receiver stall: results collect in the queue, and once fewer than two
//   entries are free s_axis_tready drops until m_axis drains them.
//   Reset (rst_n low, asynchronous): no open sequence, queue empty.
module utf8_stream_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // end_of_text
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic                 m_axis_tlast    // last_of_run
);
    import utf8d_pkg::*;

    logic                 pending_reg, pending_next;
    logic [CP_W-1:0]      acc_reg, acc_next;
    logic [LEN_W-1:0]     exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]     seen_reg, seen_next;

    result_t              rq_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]  count_reg, count_next;

    logic                 in_fire, out_fire;
    logic                 is_cont, extend, close_old;
    logic [LEN_W-1:0]     new_len;
    logic [CP_W-1:0]      old_cp, eot_cp;
    logic [CP_W-1:0]      upd_acc;
    logic [LEN_W-1:0]     upd_exp, upd_seen;
    logic                 push0, push1;
    result_t              res0, res1;
    logic [RQ_PTR_W-1:0]  wr_ptr_p1;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {1'b0, rq_reg[rd_ptr_reg].cp};
    assign m_axis_tlast  = rq_reg[rd_ptr_reg].last;

    always_comb
    begin
        is_cont   = (s_axis_tdata[7:6] == CONT_TAG);
        extend    = is_cont && pending_reg;
        close_old = !extend && pending_reg;
        new_len   = lead_length(s_axis_tdata);
        old_cp    = (seen_reg == exp_len_reg) ? acc_reg : REPLACEMENT_CP;

        if (extend)
        begin
            upd_acc  = {acc_reg[CP_W-7:0], s_axis_tdata[5:0]};
            upd_exp  = exp_len_reg;
            upd_seen = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 3'd1;
        end
        else
        begin
            upd_acc  = CP_W'(s_axis_tdata & lead_mask(new_len));
            upd_exp  = new_len;
            upd_seen = 3'd1;
        end

        eot_cp = (upd_seen == upd_exp) ? upd_acc : REPLACEMENT_CP;

        pending_next = pending_reg;
        acc_next     = acc_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        if (in_fire)
        begin
            if (s_axis_tlast)
            begin
                // close everything at end of text
                pending_next = 1'b0;
                acc_next     = '0;
                exp_len_next = '0;
                seen_next    = '0;
            end
            else
            begin
                pending_next = 1'b1;
                acc_next     = upd_acc;
                exp_len_next = upd_exp;
                seen_next    = upd_seen;
            end
        end

        push0     = in_fire && close_old;
        push1     = in_fire && s_axis_tlast;
        res0      = '{last: !s_axis_tlast, cp: old_cp};
        res1      = '{last: 1'b1, cp: eot_cp};
        wr_ptr_p1 = wr_ptr_reg + 1'b1;

        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push0) + RQ_PTR_W'(push1);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(out_fire);
        count_next  = count_reg + RQ_CNT_W'(push0) + RQ_CNT_W'(push1)
                      - RQ_CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            acc_reg     <= '0;
            exp_len_reg <= '0;
            seen_reg    <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    // Result queue payload; the end-of-text result follows the closed one
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            rq_reg[wr_ptr_reg] <= res0;
        end
        if (push1)
        begin
            if (push0)
            begin
                rq_reg[wr_ptr_p1] <= res1;
            end
            else
            begin
                rq_reg[wr_ptr_reg] <= res1;
            end
        end
    end

endmodule
